/* rtl/core/sfsi_pkg.sv */
// ----------------------------------------------------------------------------
// sfsi_pkg: shared types and constants for the span future score table
// Score format, table geometry, item codes and the saturating max-plus join.
// ----------------------------------------------------------------------------
package sfsi_pkg;

  localparam int MAX_WORDS   = 32;
  localparam int POS_W       = $clog2(MAX_WORDS);
  localparam int ADDR_W      = 2 * POS_W;
  localparam int CELL_COUNT  = MAX_WORDS * MAX_WORDS;
  localparam int SCORE_W     = 32;
  localparam int LEN_W       = 6;
  localparam int ACT_W       = 2;
  localparam int STATUS_W    = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_SENTENCE_LENGTH = '0;
  localparam logic [LEN_W-1:0]      SENTENCE_LENGTH_RST = LEN_W'(1);

  localparam logic signed [SCORE_W-1:0] NEG_INF        = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] POS_MAX        = 32'sh7fff_ffff;
  localparam logic signed [SCORE_W-1:0] NEG_MIN_FINITE = 32'sh8000_0001;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CELL  = 2'd0,
    ST_DONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // max-plus join: minus infinity absorbs, finite sums saturate to finite range
  function automatic logic signed [SCORE_W-1:0] join_scores(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    logic signed [SCORE_W:0] sum;
    sum = $signed({a[SCORE_W-1], a}) + $signed({b[SCORE_W-1], b});
    if (a == NEG_INF || b == NEG_INF) begin
      return NEG_INF;
    end else if (sum > 33'sh0_7fff_ffff) begin
      return POS_MAX;
    end else if (sum < 33'sh1_8000_0001) begin
      return NEG_MIN_FINITE;
    end else begin
      return sum[SCORE_W-1:0];
    end
  endfunction

endpackage

/* rtl/core/span_future_score_interval_dp.sv */
// ----------------------------------------------------------------------------
// span_future_score_interval_dp: span score table with max-plus completion
// Keeps the best Q16.16 score per word span in a 1024-cell table and fills
// longer spans from split points with one shared read/add/compare datapath.
// ----------------------------------------------------------------------------
// Operation: after reset, and after every clear beat, a clearing pass writes
// minus infinity to all 1024 cells, one per cycle, with in_tready low. A load
// reads its cell and writes the larger score back; a load whose span is outside
// the sentence is dropped. A query reads its cell, then waits for the output register.
// A compute beat fills every span longer than one word, shortest spans first,
// through the single table read port: each split point needs a left read, a
// right read and a compare step.
module span_future_score_interval_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_pos[4:0], end_pos[9:5], option_score[41:10], zero pad
  input  logic [sfsi_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[1:0]
  input  logic [sfsi_pkg::ACT_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cell_score[31:0], cell_empty[32], zero pad
  output logic [sfsi_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [sfsi_pkg::STATUS_W-1:0]      out_tuser,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sfsi_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [sfsi_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [sfsi_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import sfsi_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LD, S_QOUT, S_CINIT, S_CDST, S_CBEST,
    S_CRRD, S_CSUM, S_CCMP, S_CWR, S_CDONE
  } state_t;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]          sentence_length_r;
  logic [LEN_W-1:0]          n_eff;
  logic [ADDR_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0]         ld_addr_r, ld_addr_nxt;
  logic signed [SCORE_W-1:0] opt_r, opt_nxt;
  logic                      qbad_r, qbad_nxt;
  logic [POS_W-1:0]          len_r, len_nxt;
  logic [POS_W-1:0]          s_r, s_nxt;
  logic [POS_W-1:0]          k_r, k_nxt;
  logic [POS_W-1:0]          e_cur;
  logic [POS_W-1:0]          k_inc;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic signed [SCORE_W-1:0] left_r, left_nxt;
  logic signed [SCORE_W-1:0] sum_r, sum_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [SCORE_W-1:0] cell_score_r, cell_score_nxt;
  logic                      cell_empty_r, cell_empty_nxt;
  status_t                   status_r, status_nxt;

  logic [SCORE_W-1:0]        mem [CELL_COUNT];
  logic signed [SCORE_W-1:0] rd_data_r;
  logic                      rd_en, wr_en;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic signed [SCORE_W-1:0] wr_data;

  logic [POS_W-1:0]          in_start, in_end;
  logic signed [SCORE_W-1:0] in_score;
  action_t                   in_action;
  logic                      in_fire, in_span_ok, out_free;

  assign in_start   = in_tdata[POS_W-1:0];
  assign in_end     = in_tdata[2*POS_W-1:POS_W];
  assign in_score   = in_tdata[2*POS_W+SCORE_W-1:2*POS_W];
  assign in_action  = action_t'(in_tuser);

  assign n_eff      = (sentence_length_r > LEN_W'(MAX_WORDS)) ? LEN_W'(MAX_WORDS)
                                                              : sentence_length_r;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_span_ok = (in_start <= in_end) && ({1'b0, in_end} < n_eff);
  assign out_free   = !out_valid_r || out_tready;
  assign e_cur      = s_r + len_r;
  assign k_inc      = k_r + POS_W'(1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-SCORE_W-1)'(0), cell_empty_r, cell_score_r};
  assign out_tuser  = status_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_SENTENCE_LENGTH)
                      ? CFG_DATA_W'(sentence_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sentence_length_r <= SENTENCE_LENGTH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_ADDR_W-1:2] == REG_SENTENCE_LENGTH) begin
      sentence_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  // score table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    ld_addr_nxt    = ld_addr_r;
    opt_nxt        = opt_r;
    qbad_nxt       = qbad_r;
    len_nxt        = len_r;
    s_nxt          = s_r;
    k_nxt          = k_r;
    best_nxt       = best_r;
    left_nxt       = left_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cell_score_nxt = cell_score_r;
    cell_empty_nxt = cell_empty_r;
    status_nxt     = status_r;
    rd_en          = 1'b0;
    rd_addr        = {in_start, in_end};
    wr_en          = 1'b0;
    wr_addr        = {s_r, e_cur};
    wr_data        = best_r;

    unique case (state_r)
      S_CLR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = NEG_INF;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            ACT_CLEAR: state_nxt = S_CLR;
            ACT_LOAD: begin
              if (in_span_ok) begin
                rd_en       = 1'b1;
                ld_addr_nxt = {in_start, in_end};
                opt_nxt     = in_score;
                state_nxt   = S_LD;
              end
            end
            ACT_COMPUTE: state_nxt = S_CINIT;
            ACT_QUERY: begin
              rd_en     = 1'b1;
              qbad_nxt  = !in_span_ok;
              state_nxt = S_QOUT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD: begin
        wr_addr = ld_addr_r;
        wr_data = opt_r;
        wr_en   = (opt_r > rd_data_r);
        state_nxt = S_IDLE;
      end
      S_QOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          cell_score_nxt = qbad_r ? '0 : rd_data_r;
          cell_empty_nxt = !qbad_r && (rd_data_r == NEG_INF);
          status_nxt     = qbad_r ? ST_RANGE : ST_CELL;
          state_nxt      = S_IDLE;
        end
      end
      S_CINIT: begin
        len_nxt   = POS_W'(1);
        s_nxt     = '0;
        state_nxt = (n_eff <= LEN_W'(1)) ? S_CDONE : S_CDST;
      end
      S_CDST: begin
        rd_en     = 1'b1;
        rd_addr   = {s_r, e_cur};
        k_nxt     = s_r;
        state_nxt = S_CBEST;
      end
      S_CBEST: begin
        best_nxt  = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = {s_r, k_r};
        state_nxt = S_CRRD;
      end
      S_CRRD: begin
        left_nxt  = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = {k_inc, e_cur};
        state_nxt = S_CSUM;
      end
      S_CSUM: begin
        sum_nxt   = join_scores(left_r, rd_data_r);
        state_nxt = S_CCMP;
      end
      S_CCMP: begin
        if (sum_r > best_r) begin
          best_nxt = sum_r;
        end
        if (k_inc == e_cur) begin
          state_nxt = S_CWR;
        end else begin
          k_nxt     = k_inc;
          rd_en     = 1'b1;
          rd_addr   = {s_r, k_inc};
          state_nxt = S_CRRD;
        end
      end
      S_CWR: begin
        wr_en = 1'b1;
        if (({1'b0, e_cur} + LEN_W'(1)) < n_eff) begin
          s_nxt     = s_r + POS_W'(1);
          state_nxt = S_CDST;
        end else if (({1'b0, len_r} + LEN_W'(1)) < n_eff) begin
          len_nxt   = len_r + POS_W'(1);
          s_nxt     = '0;
          state_nxt = S_CDST;
        end else begin
          state_nxt = S_CDONE;
        end
      end
      S_CDONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          cell_score_nxt = '0;
          cell_empty_nxt = 1'b0;
          status_nxt     = ST_DONE;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ld_addr_r    <= ld_addr_nxt;
    opt_r        <= opt_nxt;
    qbad_r       <= qbad_nxt;
    len_r        <= len_nxt;
    s_r          <= s_nxt;
    k_r          <= k_nxt;
    best_r       <= best_nxt;
    left_r       <= left_nxt;
    sum_r        <= sum_nxt;
    cell_score_r <= cell_score_nxt;
    cell_empty_r <= cell_empty_nxt;
    status_r     <= status_nxt;
  end

  // clearing pass always runs to the end of the table
  a_clr_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLR) |-> (clr_cnt_r == '0))
    else $error("clear counter left mid-table");

  // split point stays inside the span being completed, span inside sentence
  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRRD || state_r == S_CSUM || state_r == S_CCMP) |->
      (k_r >= s_r && k_r < e_cur && {1'b0, e_cur} < n_eff))
    else $error("split point out of span");

  // results only come from a query answer or a finished compute
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_QOUT || state_r == S_CDONE))
    else $error("result beat from wrong state");

endmodule

/* bench/span_future_score_interval_dp_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// span_future_score_interval_dp_test: self-checking bench for the span table
// Drives clear, load, compute and query beats over several sentence lengths
// and idle patterns, tracks the score table in a local max-plus predictor
// and checks every result beat against the predicted answer in order.
// ----------------------------------------------------------------------------
module span_future_score_interval_dp_test;
  import sfsi_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 1100;
  localparam logic [CFG_ADDR_W-1:0] LENGTH_ADDR = {REG_SENTENCE_LENGTH, 2'b00};

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic                      empty;
    status_t                   status;
  } cell_answer_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [ACT_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  logic signed [SCORE_W-1:0] span_best [MAX_WORDS][MAX_WORDS];
  logic [LEN_W-1:0] length_reg;
  cell_answer_t pending_answers[$];
  int mismatches = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_for_results = 1'b0;

  span_future_score_interval_dp u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               pending_answers.size());
      $display("span_future_score_interval_dp_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < 50) begin
      $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    cell_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, 0);
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[SCORE_W-1:0] !== want.score) begin
          report_mismatch("cell_score", out_tdata[SCORE_W-1:0], want.score);
        end
        if (out_tdata[SCORE_W] !== want.empty) begin
          report_mismatch("cell_empty", out_tdata[SCORE_W], want.empty);
        end
        if (out_tuser !== want.status) begin
          report_mismatch("status", out_tuser, want.status);
        end
      end
    end
  end

  // ---- table predictor ----

  function automatic int active_words();
    return (length_reg > MAX_WORDS) ? MAX_WORDS : int'(length_reg);
  endfunction

  function automatic logic signed [SCORE_W-1:0] saturating_join(
    logic signed [SCORE_W-1:0] a,
    logic signed [SCORE_W-1:0] b
  );
    longint total;
    if (a == NEG_INF || b == NEG_INF) return NEG_INF;
    total = longint'(a) + longint'(b);
    if (total > longint'(POS_MAX)) return POS_MAX;
    if (total < longint'(NEG_MIN_FINITE)) return NEG_MIN_FINITE;
    return SCORE_W'(total);
  endfunction

  task automatic clear_spans();
    foreach (span_best[i, j]) span_best[i][j] = NEG_INF;
  endtask

  task automatic enqueue_answer(cell_answer_t ans);
    pending_answers.insert(pending_answers.size(), ans);
  endtask

  task automatic fill_longer_spans(int n);
    logic signed [SCORE_W-1:0] joined;
    for (int len = 1; len < n; len++) begin
      for (int s = 0; s + len < n; s++) begin
        for (int k = s; k < s + len; k++) begin
          joined = saturating_join(span_best[s][k], span_best[k+1][s+len]);
          if (joined > span_best[s][s+len]) span_best[s][s+len] = joined;
        end
      end
    end
  endtask

  task automatic apply_item(action_t act, logic [POS_W-1:0] s, logic [POS_W-1:0] e,
                            logic signed [SCORE_W-1:0] score);
    int n;
    bit in_range;
    cell_answer_t ans;
    n = active_words();
    in_range = (s <= e) && (int'(e) < n);
    ans.score = '0;
    ans.empty = 1'b0;
    case (act)
      ACT_CLEAR: begin
        clear_spans();
      end
      ACT_LOAD: begin
        if (in_range && score > span_best[s][e]) span_best[s][e] = score;
      end
      ACT_COMPUTE: begin
        fill_longer_spans(n);
        ans.status = ST_DONE;
        enqueue_answer(ans);
      end
      default: begin
        if (in_range) begin
          ans.score = span_best[s][e];
          ans.empty = (span_best[s][e] == NEG_INF);
          ans.status = ST_CELL;
        end else begin
          ans.status = ST_RANGE;
        end
        enqueue_answer(ans);
      end
    endcase
  endtask

  // ---- stimulus ----

  task automatic send_item(action_t act, logic [POS_W-1:0] s, logic [POS_W-1:0] e,
                           logic signed [SCORE_W-1:0] score);
    if (hold_for_results && act == ACT_COMPUTE && pending_answers.size() != 0) begin
      in_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {(IN_TDATA_W - 2 * POS_W - SCORE_W)'(0), score, e, s};
    in_tuser <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_item(act, s, e, score);
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(int value);
    settle_block();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= LENGTH_ADDR;
    cfg_pwdata <= {26'($urandom), LEN_W'(value)};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    length_reg = LEN_W'(value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic signed [SCORE_W-1:0] random_score();
    case ($urandom_range(9))
      0: return NEG_INF;
      1: return POS_MAX - $urandom_range(3);
      2: return NEG_MIN_FINITE + $urandom_range(3);
      3, 4: return $urandom;
      default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  task automatic send_valid(action_t act, int n);
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] e;
    s = POS_W'($urandom_range(n - 1));
    e = POS_W'($urandom_range(n - 1, s));
    send_item(act, s, e, random_score());
  endtask

  task automatic run_sentence(int count);
    int n;
    int sent;
    int pick;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] e;
    n = active_words();
    send_item(ACT_CLEAR, POS_W'($urandom), POS_W'($urandom), $urandom);
    sent = 1;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 48 && n > 0) begin
        send_valid(ACT_LOAD, n);
        sent++;
      end else if (pick < 56) begin
        s = POS_W'($urandom);
        e = POS_W'($urandom);
        send_item(ACT_LOAD, s, e, random_score());
        sent++;
      end else if (pick < 62) begin
        send_item(ACT_COMPUTE, POS_W'($urandom), POS_W'($urandom), $urandom);
        sent++;
      end else if (pick < 88 && n > 0) begin
        send_valid(ACT_QUERY, n);
        sent++;
      end else if (pick < 97) begin
        send_item(ACT_QUERY, POS_W'($urandom), POS_W'($urandom), $urandom);
        sent++;
      end else begin
        send_item(ACT_CLEAR, POS_W'($urandom), POS_W'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  // ---- tests ----

  task automatic test_directed_extremes();
    idle_pct = 0;
    stall_pct = 0;
    write_length(4);
    send_item(ACT_QUERY, 0, 0, 0);
    send_item(ACT_LOAD, 0, 0, POS_MAX);
    send_item(ACT_LOAD, 1, 1, POS_MAX);
    send_item(ACT_LOAD, 2, 2, NEG_MIN_FINITE);
    send_item(ACT_LOAD, 3, 3, NEG_MIN_FINITE);
    send_item(ACT_LOAD, 0, 0, NEG_INF);
    send_item(ACT_LOAD, 1, 1, POS_MAX);
    send_item(ACT_LOAD, 3, 0, 32'sh0001_0000);
    send_item(ACT_LOAD, 0, 4, 32'sh0001_0000);
    send_item(ACT_LOAD, 1, 2, 32'sh0005_0000);
    send_item(ACT_QUERY, 0, 0, 0);
    send_item(ACT_COMPUTE, 0, 0, 0);
    send_item(ACT_QUERY, 0, 1, 0);
    send_item(ACT_QUERY, 2, 3, 0);
    send_item(ACT_QUERY, 1, 2, 0);
    send_item(ACT_QUERY, 0, 3, 0);
    send_item(ACT_QUERY, 3, 0, 0);
    send_item(ACT_QUERY, 0, 4, 0);
    send_item(ACT_QUERY, 31, 31, 0);
    send_item(ACT_CLEAR, 31, 31, '1);
    send_item(ACT_QUERY, 0, 1, 0);
  endtask

  task automatic test_empty_sentence();
    write_length(0);
    send_item(ACT_LOAD, 0, 0, 32'sh0002_0000);
    send_item(ACT_QUERY, 0, 0, 0);
    send_item(ACT_COMPUTE, 0, 0, 0);
    send_item(ACT_QUERY, 31, 31, 0);
  endtask

  task automatic test_oversized_length();
    write_length(63);
    send_item(ACT_CLEAR, 0, 0, 0);
    send_item(ACT_LOAD, 0, 30, 32'sh0003_0000);
    send_item(ACT_LOAD, 31, 31, -32'sh0001_0000);
    send_item(ACT_QUERY, 31, 31, 0);
    send_item(ACT_QUERY, 31, 30, 0);
    send_item(ACT_COMPUTE, 0, 0, 0);
    send_item(ACT_QUERY, 0, 31, 0);
    write_length(33);
    send_item(ACT_QUERY, 0, 31, 0);
  endtask

  task automatic test_full_sentence();
    idle_pct = 36;
    stall_pct = 36;
    write_length(MAX_WORDS);
    send_item(ACT_CLEAR, 0, 0, 0);
    repeat (40) send_valid(ACT_LOAD, MAX_WORDS);
    send_item(ACT_COMPUTE, 0, 0, 0);
    repeat (20) send_valid(ACT_QUERY, MAX_WORDS);
    send_item(ACT_QUERY, 0, POS_W'(MAX_WORDS - 1), 0);
  endtask

  task automatic test_random_sentences();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      hold_for_results = (mode == 0);
      write_length($urandom_range(8, 2));
      run_sentence(90);
      write_length($urandom_range(12, 1));
      run_sentence(90);
    end
    hold_for_results = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= ACT_CLEAR;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    length_reg = SENTENCE_LENGTH_RST;
    clear_spans();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_empty_sentence();
    test_oversized_length();
    test_full_sentence();
    test_random_sentences();

    settle_block();
    if (mismatches == 0) begin
      $display("span_future_score_interval_dp_test: PASS");
    end else begin
      $display("span_future_score_interval_dp_test: FAIL");
    end
    $finish;
  end

endmodule
